[rtl/clqm_pkg.sv]
// ----------------------------------------------------------------------------
// clqm_pkg
// Shared constants, codes and controller/datapath interface types for the
// circular linked queue manager.
// ----------------------------------------------------------------------------
`default_nettype none

package clqm_pkg;

	localparam int NODES_DEF  = 64;
	localparam int QUEUES_DEF = 4;

	localparam int CMD_W  = 2;
	localparam int QID_W  = 2;
	localparam int NODE_W = 6;
	localparam int STAT_W = 2;
	localparam int SIZE_W = 7;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_LINKED = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic capture;
		logic rd_tail;
		logic wr_first;
		logic wr_remove;
		logic link_head;
		logic link_tail;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_append;
		logic is_remove;
		logic append_ok;
		logic remove_ok;
		logic q_nonempty;
	} ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/clqm_ctrl.sv]
// ----------------------------------------------------------------------------
// clqm_ctrl
// Operation sequencer: accepts a command word, decodes it against the
// datapath status and steps the link table updates.
// ----------------------------------------------------------------------------
`default_nettype none

module clqm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  clqm_pkg::ctrl_sts_t  sts,
	output logic                 busy,
	output clqm_pkg::ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEC  = 2'd1;
	localparam logic [1:0] S_APP1 = 2'd2;
	localparam logic [1:0] S_APP2 = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_append && sts.append_ok && sts.q_nonempty) begin
					cmd.rd_tail = 1'b1;
					state_d     = S_APP1;
				end else begin
					cmd.wr_first  = sts.is_append && sts.append_ok;
					cmd.wr_remove = sts.is_remove && sts.remove_ok;
					cmd.finish    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_APP1: begin
				cmd.link_head = 1'b1;
				state_d       = S_APP2;
			end
			S_APP2: begin
				cmd.link_tail = 1'b1;
				cmd.finish    = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/clqm_dp.sv]
// ----------------------------------------------------------------------------
// clqm_dp
// Link, owner, head and count tables with membership flags, command
// decode status and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clqm_dp #(
	parameter int NODES  = clqm_pkg::NODES_DEF,
	parameter int QUEUES = clqm_pkg::QUEUES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [clqm_pkg::CMD_W-1:0]        cmd_in,
	input  wire  [clqm_pkg::QID_W-1:0]        queue_id,
	input  wire  [clqm_pkg::NODE_W-1:0]       node,
	input  clqm_pkg::ctrl_cmd_t               cmd,
	output clqm_pkg::ctrl_sts_t               sts,
	output logic                              done,
	output logic [clqm_pkg::STAT_W-1:0]       status,
	output logic [clqm_pkg::SIZE_W-1:0]       occupancy,
	output logic [clqm_pkg::NODE_W-1:0]       head_node,
	output logic                              head_valid
);

	localparam int NW = $clog2(NODES);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int CW = $clog2(NODES + 1);

	logic [NW-1:0] next_mem  [NODES];
	logic [NW-1:0] prev_mem  [NODES];
	logic [QW-1:0] owner_mem [NODES];
	logic [NW-1:0] head_mem  [QUEUES];
	logic [CW-1:0] cnt_mem   [QUEUES];

	logic [NODES-1:0]  linked_q;
	logic [QUEUES-1:0] nonempty_q;

	logic [clqm_pkg::CMD_W-1:0]  cmd_q;
	logic [clqm_pkg::QID_W-1:0]  qid_q;
	logic [clqm_pkg::NODE_W-1:0] node_q;

	logic [NW-1:0] next_rd_q;
	logic [NW-1:0] prev_rd_q;
	logic [QW-1:0] owner_rd_q;
	logic [NW-1:0] head_rd_q;
	logic [CW-1:0] cnt_rd_q;

	logic [NW-1:0] nidx;
	logic [QW-1:0] qidx;
	logic [NW-1:0] nidx_in;
	logic [QW-1:0] qidx_in;
	logic          n_ok;
	logic          q_ok;
	logic          linked_n;
	logic          q_ne;
	logic [CW-1:0] cnt_cur;
	logic          append_ok;
	logic          remove_ok;

	logic          new_ne;
	logic [CW-1:0] new_cnt;
	logic [NW-1:0] new_head;
	logic [clqm_pkg::STAT_W-1:0] res_st;

	logic          next_we;
	logic [NW-1:0] next_wa;
	logic [NW-1:0] next_wd;
	logic          prev_we;
	logic [NW-1:0] prev_wa;
	logic [NW-1:0] prev_wd;
	logic [NW-1:0] prev_ra;

	assign nidx    = NW'(node_q);
	assign qidx    = QW'(qid_q);
	assign nidx_in = NW'(node);
	assign qidx_in = QW'(queue_id);
	assign n_ok    = (32'(node_q) < 32'(NODES));
	assign q_ok    = (32'(qid_q) < 32'(QUEUES));

	assign linked_n  = n_ok && linked_q[nidx];
	assign q_ne      = q_ok && nonempty_q[qidx];
	assign cnt_cur   = q_ne ? cnt_rd_q : '0;
	assign append_ok = q_ok && n_ok && !linked_n;
	assign remove_ok = q_ne && linked_n && (owner_rd_q == qidx);

	assign sts.is_append  = (cmd_q == clqm_pkg::CMD_APPEND);
	assign sts.is_remove  = (cmd_q == clqm_pkg::CMD_REMOVE);
	assign sts.append_ok  = append_ok;
	assign sts.remove_ok  = remove_ok;
	assign sts.q_nonempty = q_ne;

	// latch the command word and read every entry it may touch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q      <= cmd_in;
			qid_q      <= queue_id;
			node_q     <= node;
			next_rd_q  <= next_mem[nidx_in];
			owner_rd_q <= owner_mem[nidx_in];
			head_rd_q  <= head_mem[qidx_in];
			cnt_rd_q   <= cnt_mem[qidx_in];
		end
	end

	assign prev_ra = cmd.capture ? nidx_in : head_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.capture || cmd.rd_tail) begin
			prev_rd_q <= prev_mem[prev_ra];
		end
	end

	always_comb begin
		new_ne   = q_ne;
		new_cnt  = cnt_cur;
		new_head = head_rd_q;
		if (cmd.wr_first) begin
			new_ne   = 1'b1;
			new_cnt  = CW'(1);
			new_head = nidx;
		end else if (cmd.wr_remove) begin
			if (cnt_cur <= CW'(1)) begin
				new_ne  = 1'b0;
				new_cnt = '0;
			end else begin
				new_cnt = cnt_cur - CW'(1);
				if (head_rd_q == nidx) begin
					new_head = next_rd_q;
				end
			end
		end else if (cmd.link_tail) begin
			new_cnt = cnt_cur + CW'(1);
		end
	end

	always_comb begin
		res_st = clqm_pkg::ST_OK;
		if (!cmd.link_tail) begin
			if (sts.is_append && !append_ok) begin
				res_st = clqm_pkg::ST_LINKED;
			end else if (sts.is_remove && !q_ne) begin
				res_st = clqm_pkg::ST_EMPTY;
			end else if (sts.is_remove && !remove_ok) begin
				res_st = clqm_pkg::ST_ABSENT;
			end
		end
	end

	always_comb begin
		next_we = 1'b0;
		next_wa = nidx;
		next_wd = nidx;
		prev_we = 1'b0;
		prev_wa = nidx;
		prev_wd = nidx;
		if (cmd.wr_first) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (cmd.wr_remove) begin
			next_we = 1'b1;
			next_wa = prev_rd_q;
			next_wd = next_rd_q;
			prev_we = 1'b1;
			prev_wa = next_rd_q;
			prev_wd = prev_rd_q;
		end else if (cmd.link_head) begin
			next_we = 1'b1;
			next_wd = head_rd_q;
			prev_we = 1'b1;
			prev_wa = head_rd_q;
		end else if (cmd.link_tail) begin
			next_we = 1'b1;
			next_wa = prev_rd_q;
			prev_we = 1'b1;
			prev_wd = prev_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_first || cmd.link_tail) begin
			owner_mem[nidx] <= qidx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_first || cmd.wr_remove) begin
			head_mem[qidx] <= new_head;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_first || cmd.wr_remove || cmd.link_tail) begin
			cnt_mem[qidx] <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q   <= '0;
			nonempty_q <= '0;
		end else begin
			if (cmd.wr_first || cmd.link_tail) begin
				linked_q[nidx] <= 1'b1;
			end else if (cmd.wr_remove) begin
				linked_q[nidx] <= 1'b0;
			end
			if (cmd.wr_first || cmd.wr_remove) begin
				nonempty_q[qidx] <= new_ne;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status     <= res_st;
			occupancy  <= clqm_pkg::SIZE_W'(new_cnt);
			head_node  <= new_ne ? clqm_pkg::NODE_W'(new_head) : '0;
			head_valid <= new_ne;
		end
	end

endmodule

`default_nettype wire

[rtl/circular_linked_queue_manager_unit.sv]
// ----------------------------------------------------------------------------
// circular_linked_queue_manager_unit
// Circular doubly linked queue manager over a fixed node pool.
// ----------------------------------------------------------------------------
// A command word is taken at a clock edge with start high and busy low. Query,
// remove, every rejected command and an append to an empty queue finish in
// the decode state; an append to a non-empty queue adds two link steps, as the
// next and prev link tables are single-port memories and linking at the tail
// writes two entries of each. The result word appears on status, occupancy,
// head_node and head_valid for exactly one cycle with done high, in the cycle
// after the command completes; busy is already low then, so the next command
// may be taken in that same cycle. The receiver cannot stall the result.
// Membership flags clear at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_linked_queue_manager_unit #(
	parameter int NODES  = clqm_pkg::NODES_DEF,
	parameter int QUEUES = clqm_pkg::QUEUES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [clqm_pkg::CMD_W-1:0]   cmd,
	input  wire  [clqm_pkg::QID_W-1:0]   queue_id,
	input  wire  [clqm_pkg::NODE_W-1:0]  node,
	output logic                         done,
	output logic [clqm_pkg::STAT_W-1:0]  status,
	output logic [clqm_pkg::SIZE_W-1:0]  occupancy,
	output logic [clqm_pkg::NODE_W-1:0]  head_node,
	output logic                         head_valid
);

	clqm_pkg::ctrl_cmd_t ctl;
	clqm_pkg::ctrl_sts_t sts;

	clqm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (ctl)
	);

	clqm_dp #(
		.NODES  (NODES),
		.QUEUES (QUEUES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_in     (cmd),
		.queue_id   (queue_id),
		.node       (node),
		.cmd        (ctl),
		.sts        (sts),
		.done       (done),
		.status     (status),
		.occupancy  (occupancy),
		.head_node  (head_node),
		.head_valid (head_valid)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an operation in flight");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.wr_first, ctl.wr_remove, ctl.link_head, ctl.link_tail}))
		else $error("conflicting table updates");

	a_valid_size: assert property (@(posedge clk) disable iff (!arst_n)
		done && head_valid |-> occupancy != '0)
		else $error("non-empty queue reported with zero size");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && !head_valid |-> occupancy == '0 && head_node == '0)
		else $error("empty queue reported with size or head");
`endif

endmodule

`default_nettype wire
